### hdl/integer_to_ascii_formatter_defines.svh
// Assertion macros shared by the integer-to-ASCII formatter RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high.
`define ITOA_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoa check failed");
// Next-cycle implication, disabled while reset is high.
`define ITOA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoa check failed");
`else
`define ITOA_ASSERT_IMPL(name, clk, rst, ante, cons)
`define ITOA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

### hdl/itoa_pkg.sv
// Types, constants and helper functions of the integer-to-ASCII formatter.
// Used by itoa_dabble_stage and integer_to_ascii_formatter; depends on nothing.
`default_nettype none
package itoa_pkg;

   localparam int ValueWidth    = 32;
   localparam int CharWidth     = 8;
   localparam int DigitWidth    = 4;
   localparam int DecDigits     = 10;
   localparam int HexDigits     = 8;
   localparam int MaxChars      = 10;
   localparam int BcdWidth      = DecDigits * DigitWidth;
   localparam int DabbleStages  = 4;
   localparam int StepsPerStage = ValueWidth / DabbleStages;
   localparam int CountWidth    = $clog2(MaxChars + 1);

   localparam logic [CharWidth-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_A    = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_X    = 8'h78;
   localparam logic [DigitWidth-1:0] NIB_TEN  = 4'ha;

   typedef enum logic {
      OP_DEC = 1'b0,
      OP_HEX = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [ValueWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_out;
      logic                 last;
   } rsp_type;

   // Item in flight through the binary-to-BCD stages. The binary word is
   // rotated, so after all stages it holds the original value again.
   typedef struct packed {
      opcode_type            opcode;
      logic [ValueWidth-1:0] bin;
      logic [BcdWidth-1:0]   bcd;
   } dabble_type;

   // Formatted text, first character at index 0, and its length.
   typedef struct packed {
      logic [MaxChars-1:0][CharWidth-1:0] chars;
      logic [CountWidth-1:0]              count;
   } fmt_type;

   function automatic logic [CharWidth-1:0] hex_char(input logic [DigitWidth-1:0] nib);
      logic [CharWidth-1:0] ch;
      if (nib < NIB_TEN) begin
         ch = CHAR_ZERO + {{(CharWidth-DigitWidth){1'b0}}, nib};
      end else begin
         ch = CHAR_A + {{(CharWidth-DigitWidth){1'b0}}, nib - NIB_TEN};
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

### hdl/itoa_dabble_stage.sv
// One registered stage of the shift-and-add-3 binary-to-BCD converter.
// Depends on itoa_pkg.
`default_nettype none
module itoa_dabble_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire logic                in_valid,
   input  wire itoa_pkg::dabble_type in_data,
   output      logic                out_valid,
   output      itoa_pkg::dabble_type out_data
);
   import itoa_pkg::*;

   logic       valid_ff;
   dabble_type data_ff;
   dabble_type data_in;

   // Each step corrects every BCD digit of five or more, then shifts in the
   // next binary bit from the top.
   always_comb begin
      logic [ValueWidth-1:0] bin;
      logic [BcdWidth-1:0]   bcd;
      bin = in_data.bin;
      bcd = in_data.bcd;
      for (int s = 0; s < StepsPerStage; s++) begin
         for (int d = 0; d < DecDigits; d++) begin
            if (bcd[d*DigitWidth +: DigitWidth] >= 4'd5) begin
               bcd[d*DigitWidth +: DigitWidth] = bcd[d*DigitWidth +: DigitWidth] + 4'd3;
            end
         end
         bcd = {bcd[BcdWidth-2:0], bin[ValueWidth-1]};
         bin = {bin[ValueWidth-2:0], bin[ValueWidth-1]};
      end
      data_in.opcode = in_data.opcode;
      data_in.bin    = bin;
      data_in.bcd    = bcd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### hdl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: BCD pipeline, text formatter
// and character serializer. Depends on itoa_pkg, itoa_dabble_stage and the
// assertion macros in integer_to_ascii_formatter_defines.svh.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  opcode, value
//   rsp_      out        rsp_valid / rsp_stall  char_out, last
//
// An item passes four BCD conversion stages, one formatting stage and the
// serializer load before its first character is on rsp_. The serializer
// then sends one character per cycle while rsp_stall is low: 1 to 10
// characters for a decimal item, 10 for a hex item; this sets the sustained
// item rate.
// Reset is synchronous and clears all valid bits and the serializer.
// A stall on rsp_ holds the current character; the five pipeline registers
// keep filling behind it until they are full, and only then is req_stall raised.
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"
module integer_to_ascii_formatter (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire itoa_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   // Pipeline of BCD conversion stages. Index 0 is the input port, index k
   // is the output register of stage k-1.
   logic                  stg_valid [0:DabbleStages];
   dabble_type            stg_data  [0:DabbleStages];
   logic                  stg_ready [0:DabbleStages-1];

   logic                  fmt_valid_ff;
   fmt_type               fmt_ff;
   fmt_type               fmt_in;
   logic                  fmt_ready;

   logic                  busy_ff;
   logic                  busy_in;
   logic [CountWidth-1:0] left_ff;
   logic [CountWidth-1:0] left_in;
   logic [MaxChars-1:0][CharWidth-1:0] buf_ff;
   logic [MaxChars-1:0][CharWidth-1:0] buf_in;
   logic                  ser_last;
   logic                  ser_take;
   logic                  ser_ready;
   logic                  ser_load;

   assign stg_valid[0]       = req_valid;
   assign stg_data[0].opcode = req_data.opcode;
   assign stg_data[0].bin    = req_data.value;
   assign stg_data[0].bcd    = '0;

   // A stage takes a new item when it is empty or its item moves on.
   for (genvar s = 0; s < DabbleStages; s++) begin : g_stage
      if (s == DabbleStages - 1) begin : g_tail
         assign stg_ready[s] = !stg_valid[s+1] || fmt_ready;
      end else begin : g_body
         assign stg_ready[s] = !stg_valid[s+1] || stg_ready[s+1];
      end

      itoa_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .load      (stg_ready[s]),
         .in_valid  (stg_valid[s]),
         .in_data   (stg_data[s]),
         .out_valid (stg_valid[s+1]),
         .out_data  (stg_data[s+1])
      );
   end

   assign req_stall = !stg_ready[0];

   // Formatting stage. In decimal mode the leading zero digits are counted
   // (the least significant digit always stays) and the BCD word is shifted
   // so the first printed digit lands in character 0. In hex mode the text
   // is the prefix followed by the eight nibbles of the value, which the
   // rotating binary word has restored by now.
   always_comb begin
      logic [CountWidth-1:0] lz;
      logic                  seen;
      logic [BcdWidth-1:0]   shifted;
      logic [ValueWidth-1:0] value;
      lz      = '0;
      seen    = 1'b0;
      value   = stg_data[DabbleStages].bin;
      for (int i = DecDigits - 1; i >= 1; i--) begin
         if (!seen && stg_data[DabbleStages].bcd[i*DigitWidth +: DigitWidth] == '0) begin
            lz = lz + 1'b1;
         end else begin
            seen = 1'b1;
         end
      end
      shifted = stg_data[DabbleStages].bcd << {lz, 2'b00};
      fmt_in  = '0;
      if (stg_data[DabbleStages].opcode == OP_HEX) begin
         fmt_in.chars[0] = CHAR_ZERO;
         fmt_in.chars[1] = CHAR_X;
         for (int j = 0; j < HexDigits; j++) begin
            fmt_in.chars[j+2] = hex_char(value[(HexDigits-1-j)*DigitWidth +: DigitWidth]);
         end
         fmt_in.count = CountWidth'(MaxChars);
      end else begin
         for (int j = 0; j < DecDigits; j++) begin
            fmt_in.chars[j] = CHAR_ZERO + {{(CharWidth-DigitWidth){1'b0}},
                              shifted[(DecDigits-1-j)*DigitWidth +: DigitWidth]};
         end
         fmt_in.count = CountWidth'(DecDigits) - lz;
      end
   end

   assign fmt_ready = !fmt_valid_ff || ser_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_valid_ff <= 1'b0;
      end else if (fmt_ready) begin
         fmt_valid_ff <= stg_valid[DabbleStages];
      end
   end

   always_ff @(posedge clock) begin
      if (fmt_ready && stg_valid[DabbleStages]) begin
         fmt_ff <= fmt_in;
      end
   end

   // Character serializer. Character 0 of the buffer is the one on the
   // output; the buffer shifts down by one character each time it is taken.
   // A new item loads in the same cycle that the last character goes out.
   assign ser_last  = (left_ff == CountWidth'(1));
   assign ser_take  = busy_ff && !rsp_stall;
   assign ser_ready = !busy_ff || (ser_take && ser_last);
   assign ser_load  = ser_ready && fmt_valid_ff;

   always_comb begin
      busy_in = busy_ff;
      left_in = left_ff;
      buf_in  = buf_ff;
      if (ser_load) begin
         busy_in = 1'b1;
         left_in = fmt_ff.count;
         buf_in  = fmt_ff.chars;
      end else if (ser_take) begin
         busy_in = !ser_last;
         left_in = left_ff - 1'b1;
         buf_in  = buf_ff >> CharWidth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign rsp_valid         = busy_ff;
   assign rsp_data.char_out = buf_ff[0];
   assign rsp_data.last     = ser_last;

   // While busy, the serializer holds between one and ten characters.
   `ITOA_ASSERT_IMPL(a_left_range, clock, reset, busy_ff,
                     left_ff != '0 && left_ff <= CountWidth'(MaxChars))
   // Taking a character that is not the last never ends the item.
   `ITOA_ASSERT_NEXT(a_no_early_end, clock, reset, ser_take && !ser_last, busy_ff)
   // Hex text is always ten characters long.
   `ITOA_ASSERT_IMPL(a_hex_len, clock, reset, fmt_valid_ff && fmt_ff.chars[1] == CHAR_X,
                     fmt_ff.count == CountWidth'(MaxChars))
   // Multi-digit decimal text never starts with a zero digit.
   `ITOA_ASSERT_IMPL(a_no_lead_zero, clock, reset,
                     fmt_valid_ff && fmt_ff.chars[1] != CHAR_X && fmt_ff.count != CountWidth'(1),
                     fmt_ff.chars[0] != CHAR_ZERO)

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for integer_to_ascii_formatter: directed and random numbers
// in both modes, checked one character at a time against a predictor kept here.
// Depends on itoa_pkg and the formatter RTL only.
`default_nettype none
module testbench;
   import itoa_pkg::*;

   // ASCII codes that the predictor builds its text from.
   localparam logic [7:0] ASCII_ZERO    = 8'h30;
   localparam logic [7:0] ASCII_LOWER_A = 8'h61;
   localparam logic [7:0] ASCII_LOWER_X = 8'h78;

   // Settle time after the last expected character, and the overall time limit.
   localparam int TAIL_CYCLES = 20;
   localparam int RUN_LIMIT   = 2_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Characters still owed by the block, oldest first.
   rsp_type pending_chars[$];

   // When set, neither side idles: the block runs at its full rate.
   bit quiet_run = 1'b0;

   int error_count   = 0;
   int dec_items     = 0;
   int hex_items     = 0;
   int chars_checked = 0;

   integer_to_ascii_formatter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever begin
         #2 clock = ~clock;
      end
   end

   // Hard limit on the run; far above the slowest correct run, in which every
   // item yields ten characters and each one waits out a long output stall.
   initial begin
      #RUN_LIMIT;
      $display("Timeout with %0d characters still pending.", pending_chars.size());
      $display("** integer_to_ascii_formatter: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic void push_char(input logic [7:0] ch, input logic is_last);
      rsp_type entry;
      entry.char_out = ch;
      entry.last     = is_last;
      pending_chars.insert(pending_chars.size(), entry);
   endfunction

   // Appends the text of one number to the queue of pending characters.
   // Decimal: leading zeros are dropped, but the units digit always stays.
   // Hex: "0x" and then all eight nibbles, most significant first.
   function automatic void format_number(input opcode_type op, input logic [31:0] v);
      logic [31:0] digit_buf [10];
      logic [31:0] rest;
      logic [3:0]  nib;
      int          lead;
      if (op == OP_DEC) begin
         rest = v;
         for (int i = 9; i >= 0; i--) begin
            digit_buf[i] = rest % 10;
            rest         = rest / 10;
         end
         lead = 0;
         while (lead < 9 && digit_buf[lead] == 0) begin
            lead++;
         end
         for (int i = lead; i < 10; i++) begin
            push_char(ASCII_ZERO + digit_buf[i][7:0], i == 9);
         end
      end else begin
         push_char(ASCII_ZERO, 1'b0);
         push_char(ASCII_LOWER_X, 1'b0);
         for (int i = 7; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if (nib < 4'd10) begin
               push_char(ASCII_ZERO + {4'd0, nib}, i == 0);
            end else begin
               push_char(ASCII_LOWER_A + {4'd0, nib} - 8'd10, i == 0);
            end
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Output side: random stalls and the character checker
   // ------------------------------------------------------------------

   // The receiver stalls in about 30 percent of cycles, except during a
   // quiet run, when it takes every character as soon as it appears.
   always @(posedge clock) begin
      if (reset || quiet_run) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 30);
      end
   end

   // Every character that crosses the output handshake is compared with the
   // oldest pending one. Signals are read at the edge, before any update.
   always @(posedge clock) begin : check_chars
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character: char_out %h, last %b",
                   rsp_data.char_out, rsp_data.last);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_data.char_out !== want.char_out) begin
               $error("char_out mismatch: expected %h, actual %h",
                      want.char_out, rsp_data.char_out);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last mismatch: expected %b, actual %b", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Presents one number and returns in the time step of the edge at which
   // the block took it. Outside a quiet run the sender sometimes idles first,
   // with gaps of different lengths so they land on every phase of the
   // serializer's output. The valid line is only lowered when a gap follows,
   // so it is never lowered and raised again within one time step.
   task automatic send_number(input opcode_type op, input logic [31:0] v);
      req_type     item;
      int unsigned gap;
      item.opcode = op;
      item.value  = v;
      if (!quiet_run && $urandom_range(99) < 30) begin
         gap = $urandom_range(12, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      // The first character must still pass the BCD stages, the formatter and the
      // serializer, so the expectation is always queued before it can appear.
      format_number(op, v);
      if (op == OP_HEX) begin
         hex_items++;
      end else begin
         dec_items++;
      end
   endtask

   // Stops sending and waits until every pending character has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Random values with a spread of decimal lengths, so that short numbers
   // and numbers with leading zeros in their BCD form are frequent, plus some
   // values near the two ends of the range.
   function automatic logic [31:0] random_value();
      int unsigned pick;
      int unsigned ndig;
      logic [31:0] ceiling;
      pick = $urandom_range(99);
      if (pick < 35) begin
         return $urandom;
      end
      if (pick < 85) begin
         ndig    = $urandom_range(9, 1);
         ceiling = 1;
         repeat (ndig) ceiling = ceiling * 10;
         return $urandom_range(ceiling - 1, 0);
      end
      if (pick < 93) begin
         return $urandom_range(15, 0);
      end
      return 32'hFFFF_FFFF - $urandom_range(15, 0);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Zero, single digits, the length boundaries around powers of ten and the
   // largest value, which needs all ten decimal digits.
   task automatic test_decimal_edges();
      send_number(OP_DEC, 32'd0);
      send_number(OP_DEC, 32'd1);
      send_number(OP_DEC, 32'd9);
      send_number(OP_DEC, 32'd10);
      send_number(OP_DEC, 32'd99);
      send_number(OP_DEC, 32'd100);
      send_number(OP_DEC, 32'd999_999_999);
      send_number(OP_DEC, 32'd1_000_000_000);
      send_number(OP_DEC, 32'hFFFF_FFFF);
   endtask

   // Zero padding, all sixteen nibble values and the top bit alone.
   task automatic test_hex_edges();
      send_number(OP_HEX, 32'h0000_0000);
      send_number(OP_HEX, 32'hFFFF_FFFF);
      send_number(OP_HEX, 32'h1234_5678);
      send_number(OP_HEX, 32'h9ABC_DEF0);
      send_number(OP_HEX, 32'h0000_000A);
      send_number(OP_HEX, 32'h8000_0000);
   endtask

   // Random mode and value. Halfway through, the sender stops until the
   // block has delivered everything, then carries on from an empty block.
   task automatic test_random_mix();
      for (int n = 0; n < 100; n++) begin
         send_number(opcode_type'($urandom_range(1, 0)), random_value());
         if (n == 49) begin
            wait_for_drain();
         end
      end
   endtask

   // A stretch with no idling on either side, so the block runs flat out.
   task automatic test_back_to_back();
      quiet_run = 1'b1;
      for (int n = 0; n < 12; n++) begin
         send_number(opcode_type'($urandom_range(1, 0)), random_value());
      end
      quiet_run = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_decimal_edges();
      test_hex_edges();
      test_random_mix();
      test_back_to_back();

      // Let the block finish, then watch a while longer for stray output.
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d decimal and %0d hex numbers; %0d characters compared.",
               dec_items, hex_items, chars_checked);
      $display("Covered zero, length boundaries, every hex nibble, gaps, stalls and a drain.");
      if (error_count == 0) begin
         $display("** integer_to_ascii_formatter: PASSED **");
      end else begin
         $display("** integer_to_ascii_formatter: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
